/* sv/tlik_pkg.sv */
// tlik_pkg: widths, stage types and arithmetic helpers shared by the
// two-link planar ik pipeline. No dependencies.
`timescale 1ns / 1ps

package tlik_pkg;

  localparam int COORD_BITS = 24;
  localparam int LINK_BITS  = 22;
  localparam int DIFF_W     = COORD_BITS + 2;       // target - base - shoulder
  localparam int MAG_W      = COORD_BITS + 1;       // |dx|, |dy|
  localparam int U_W        = 30;                   // normalized vector width
  localparam int SH_W       = 5;
  localparam int SUM_W      = 2 * MAG_W + 1;        // dx^2 + dy^2
  localparam int LSQ_W      = 2 * LINK_BITS + 2;    // (2L)^2
  localparam int SQ_W       = LSQ_W + 16;           // root radicand
  localparam int SQ_STEPS   = SQ_W / 2;
  localparam int RT_W       = SQ_STEPS;
  localparam int PROD_W     = 55;
  localparam int RM_W       = PROD_W + 1;
  localparam int DEN_W      = RT_W + 1;
  localparam int DIV_STEPS  = 24;
  localparam int QW         = DIV_STEPS;
  localparam int EXT_W      = DIFF_W + 2;

  localparam logic [LINK_BITS-1:0] LINK_RESET = LINK_BITS'(25600);
  localparam logic [LSQ_W-1:0] L4SQ_RESET =
    LSQ_W'(64'(LINK_RESET) * 64'(LINK_RESET) * 64'd4);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
    logic signed [COORD_BITS-1:0] shoulder_dx;
    logic signed [COORD_BITS-1:0] shoulder_dy;
    logic                         elbow_side;
    logic                         arm_alive;
  } item_t;

  // side info that travels with every item down the pipe
  typedef struct packed {
    logic                     alive;
    logic                     side;
    logic                     reach;
    logic                     zero;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [U_W-1:0]           mx;
    logic [U_W-1:0]           my;
  } ctl_t;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W-1:0] r;
  } sq_pair_t;

  typedef struct packed {
    logic [RM_W-1:0] rem;
    logic            qbit;
  } div_pair_t;

  function automatic sq_pair_t sqrt_step(input logic [SQ_W-1:0] v,
                                         input logic [SQ_W-1:0] r,
                                         input logic [SQ_W-1:0] b);
    sq_pair_t res;
    logic [SQ_W-1:0] t;
    t = r + b;
    if (v >= t) begin
      res.v = v - t;
      res.r = (r >> 1) + b;
    end else begin
      res.v = v;
      res.r = r >> 1;
    end
    return res;
  endfunction

  function automatic div_pair_t div_step(input logic [RM_W-1:0] rem,
                                         input logic [RM_W-1:0] dsh);
    div_pair_t res;
    if (rem >= dsh) begin
      res.rem  = rem - dsh;
      res.qbit = 1'b1;
    end else begin
      res.rem  = rem;
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [EXT_W-1:0] ext_d(input logic signed [DIFF_W-1:0] d);
    return $signed({{(EXT_W - DIFF_W){d[DIFF_W-1]}}, d});
  endfunction

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] lo;
    hi = $signed({{(EXT_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}});
    lo = -hi - EXT_W'(1);
    if (v > hi) begin
      return hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      return lo[COORD_BITS-1:0];
    end else begin
      return v[COORD_BITS-1:0];
    end
  endfunction

endpackage

/* sv/tlik_front.sv */
// tlik_front: five pipeline stages from the input beat to the root radicands:
// difference vector, magnitudes, squares and shift, normalized squares and
// reach compare, radicand select. Depends on tlik_pkg.
`timescale 1ns / 1ps

module tlik_front
  import tlik_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  item_t                item_i,
  input  logic [LINK_BITS:0]   two_l_i,
  input  logic [LSQ_W-1:0]     l4sq_i,
  output logic                 valid_o,
  output ctl_t                 ctl_o,
  output logic [SQ_W-1:0]      sq1_o,
  output logic [SQ_W-1:0]      sq2_o
);

  function automatic logic signed [DIFF_W-1:0] ext_c(input logic signed [COORD_BITS-1:0] c);
    return $signed({{(DIFF_W - COORD_BITS){c[COORD_BITS-1]}}, c});
  endfunction

  // stage 1
  logic                     v1_q, side1_q, alive1_q;
  logic signed [DIFF_W-1:0] dx1_q, dy1_q;
  // stage 2
  logic                     v2_q, side2_q, alive2_q, zero2_q;
  logic signed [DIFF_W-1:0] dx2_q, dy2_q;
  logic [MAG_W-1:0]         ax2_q, ay2_q;
  logic [SH_W-1:0]          sh2_q;
  // stage 3
  logic                     v3_q, side3_q, alive3_q, zero3_q, box3_q;
  logic signed [DIFF_W-1:0] dx3_q, dy3_q;
  logic [MAG_W-1:0]         ax3_q, ay3_q;
  logic [U_W-1:0]           ux3_q, uy3_q;
  logic [SUM_W-1:0]         sum3_q;
  // stage 4
  logic                     v4_q, side4_q, alive4_q, zero4_q, box4_q, lt4_q;
  logic signed [DIFF_W-1:0] dx4_q, dy4_q;
  logic [MAG_W-1:0]         ax4_q, ay4_q;
  logic [U_W-1:0]           ux4_q, uy4_q;
  logic [LSQ_W-1:0]         sum4_q, q4_q;
  logic [SQ_W-1:0]          uu4_q;
  // stage 5
  logic                     v5_q;
  ctl_t                     ctl5_q;
  logic [SQ_W-1:0]          sq1_q, sq2_q;

  logic [MAG_W-1:0] ax_d, ay_d, m_d;
  logic [SH_W-1:0]  msb_d;
  logic             reach_d;

  assign ax_d = dx1_q[DIFF_W-1] ? MAG_W'(-dx1_q) : MAG_W'(dx1_q);
  assign ay_d = dy1_q[DIFF_W-1] ? MAG_W'(-dy1_q) : MAG_W'(dy1_q);
  assign m_d  = ax_d | ay_d;

  // leading one of the larger magnitude
  always_comb begin
    msb_d = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m_d[i]) msb_d = SH_W'(i);
    end
  end

  assign reach_d = box4_q && lt4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q    <= ext_c(item_i.target_x) - ext_c(item_i.base_x) - ext_c(item_i.shoulder_dx);
      dy1_q    <= ext_c(item_i.target_y) - ext_c(item_i.base_y) - ext_c(item_i.shoulder_dy);
      side1_q  <= item_i.elbow_side;
      alive1_q <= item_i.arm_alive;

      dx2_q    <= dx1_q;
      dy2_q    <= dy1_q;
      side2_q  <= side1_q;
      alive2_q <= alive1_q;
      ax2_q    <= ax_d;
      ay2_q    <= ay_d;
      zero2_q  <= (m_d == '0);
      sh2_q    <= SH_W'(U_W - 1) - msb_d;

      dx3_q    <= dx2_q;
      dy3_q    <= dy2_q;
      side3_q  <= side2_q;
      alive3_q <= alive2_q;
      zero3_q  <= zero2_q;
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      sum3_q   <= SUM_W'(ax2_q * ax2_q) + SUM_W'(ay2_q * ay2_q);
      ux3_q    <= U_W'(ax2_q) << sh2_q;
      uy3_q    <= U_W'(ay2_q) << sh2_q;
      box3_q   <= (ax2_q < MAG_W'(two_l_i)) && (ay2_q < MAG_W'(two_l_i));

      dx4_q    <= dx3_q;
      dy4_q    <= dy3_q;
      side4_q  <= side3_q;
      alive4_q <= alive3_q;
      zero4_q  <= zero3_q;
      box4_q   <= box3_q;
      ax4_q    <= ax3_q;
      ay4_q    <= ay3_q;
      ux4_q    <= ux3_q;
      uy4_q    <= uy3_q;
      uu4_q    <= SQ_W'(ux3_q * ux3_q) + SQ_W'(uy3_q * uy3_q);
      lt4_q    <= sum3_q < SUM_W'(l4sq_i);
      q4_q     <= l4sq_i - sum3_q[LSQ_W-1:0];
      sum4_q   <= sum3_q[LSQ_W-1:0];

      ctl5_q.alive <= alive4_q;
      ctl5_q.side  <= side4_q;
      ctl5_q.reach <= reach_d;
      ctl5_q.zero  <= zero4_q;
      ctl5_q.dx    <= dx4_q;
      ctl5_q.dy    <= dy4_q;
      // x lane pairs |dy| with the half chord when reachable
      ctl5_q.mx    <= reach_d ? U_W'(ay4_q) : ux4_q;
      ctl5_q.my    <= reach_d ? U_W'(ax4_q) : uy4_q;
      sq1_q        <= reach_d ? {q4_q, 16'd0} : uu4_q;
      sq2_q        <= {sum4_q, 16'd0};
    end
  end

  assign valid_o = v5_q;
  assign ctl_o   = ctl5_q;
  assign sq1_o   = sq1_q;
  assign sq2_o   = sq2_q;

endmodule

/* sv/tlik_sqrt.sv */
// tlik_sqrt: two-lane pipelined integer square root, one result bit per
// stage. Depends on tlik_pkg.
`timescale 1ns / 1ps

module tlik_sqrt
  import tlik_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ctl_t             ctl_i,
  input  logic [SQ_W-1:0]  sq1_i,
  input  logic [SQ_W-1:0]  sq2_i,
  output logic             valid_o,
  output ctl_t             ctl_o,
  output logic [RT_W-1:0]  rt1_o,
  output logic [RT_W-1:0]  rt2_o
);

  logic            vld_q [SQ_STEPS];
  ctl_t            ctl_q [SQ_STEPS];
  logic [SQ_W-1:0] v1_q  [SQ_STEPS];
  logic [SQ_W-1:0] r1_q  [SQ_STEPS];
  logic [SQ_W-1:0] v2_q  [SQ_STEPS];
  logic [SQ_W-1:0] r2_q  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BitK = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic            src_vld;
    ctl_t            src_ctl;
    logic [SQ_W-1:0] src_v1, src_r1, src_v2, src_r2;
    sq_pair_t        n1, n2;

    if (k == 0) begin : g_first
      assign src_vld = valid_i;
      assign src_ctl = ctl_i;
      assign src_v1  = sq1_i;
      assign src_r1  = '0;
      assign src_v2  = sq2_i;
      assign src_r2  = '0;
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      assign src_ctl = ctl_q[k-1];
      assign src_v1  = v1_q[k-1];
      assign src_r1  = r1_q[k-1];
      assign src_v2  = v2_q[k-1];
      assign src_r2  = r2_q[k-1];
    end

    assign n1 = sqrt_step(src_v1, src_r1, BitK);
    assign n2 = sqrt_step(src_v2, src_r2, BitK);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k] <= src_ctl;
        v1_q[k]  <= n1.v;
        r1_q[k]  <= n1.r;
        v2_q[k]  <= n2.v;
        r2_q[k]  <= n2.r;
      end
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign ctl_o   = ctl_q[SQ_STEPS-1];
  assign rt1_o   = r1_q[SQ_STEPS-1][RT_W-1:0];
  assign rt2_o   = r2_q[SQ_STEPS-1][RT_W-1:0];

endmodule

/* sv/tlik_div.sv */
// tlik_div: two-lane pipelined restoring divider over a shared divisor,
// one quotient bit per stage. Depends on tlik_pkg.
`timescale 1ns / 1ps

module tlik_div
  import tlik_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ctl_t             ctl_i,
  input  logic [RM_W-1:0]  nx_i,
  input  logic [RM_W-1:0]  ny_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output ctl_t             ctl_o,
  output logic [QW-1:0]    qx_o,
  output logic [QW-1:0]    qy_o
);

  logic             vld_q [DIV_STEPS];
  ctl_t             ctl_q [DIV_STEPS];
  logic [RM_W-1:0]  rx_q  [DIV_STEPS];
  logic [RM_W-1:0]  ry_q  [DIV_STEPS];
  logic [DEN_W-1:0] den_q [DIV_STEPS];
  logic [QW-1:0]    qx_q  [DIV_STEPS];
  logic [QW-1:0]    qy_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int Sh = DIV_STEPS - 1 - k;
    logic             src_vld;
    ctl_t             src_ctl;
    logic [RM_W-1:0]  src_rx, src_ry, dsh;
    logic [DEN_W-1:0] src_den;
    logic [QW-1:0]    src_qx, src_qy;
    div_pair_t        nx, ny;

    if (k == 0) begin : g_first
      assign src_vld = valid_i;
      assign src_ctl = ctl_i;
      assign src_rx  = nx_i;
      assign src_ry  = ny_i;
      assign src_den = den_i;
      assign src_qx  = '0;
      assign src_qy  = '0;
    end else begin : g_next
      assign src_vld = vld_q[k-1];
      assign src_ctl = ctl_q[k-1];
      assign src_rx  = rx_q[k-1];
      assign src_ry  = ry_q[k-1];
      assign src_den = den_q[k-1];
      assign src_qx  = qx_q[k-1];
      assign src_qy  = qy_q[k-1];
    end

    assign dsh = RM_W'(src_den) << Sh;
    assign nx  = div_step(src_rx, dsh);
    assign ny  = div_step(src_ry, dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[k] <= src_ctl;
        den_q[k] <= src_den;
        rx_q[k]  <= nx.rem;
        ry_q[k]  <= ny.rem;
        qx_q[k]  <= {src_qx[QW-2:0], nx.qbit};
        qy_q[k]  <= {src_qy[QW-2:0], ny.qbit};
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign ctl_o   = ctl_q[DIV_STEPS-1];
  assign qx_o    = qx_q[DIV_STEPS-1];
  assign qy_o    = qy_q[DIV_STEPS-1];

endmodule

/* sv/two_link_planar_ik.sv */
// two_link_planar_ik: top level of the two-link planar ik pipeline, with the
// link length register, scaling, sign and output stages.
// Depends on tlik_pkg, tlik_front, tlik_sqrt and tlik_div.
//
//  channel   dir  beat                   payload
//  s_axis    in   tvalid & tready        tdata 144b, tuser 2b
//  m_axis    out  tvalid & tready        tdata 96b, tuser 2b
//  cfg       in   cfg_valid_i & ready    link_length, 22b
//
// one beat enters per cycle while the output is not stalled; the bit-per-stage
// root (31 stages) and divider (24 stages) make up most of the pipe depth.
// the whole pipe advances together; a stalled output holds every stage.
// reset clears all valid bits and loads link_length with 25600.
`timescale 1ns / 1ps

module two_link_planar_ik
  import tlik_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // target_x, target_y, base_x, base_y, shoulder_dx, shoulder_dy
  input  logic [6*COORD_BITS-1:0] s_axis_tdata,
  // elbow_side, arm_alive
  input  logic [1:0]             s_axis_tuser,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // elbow_x, elbow_y, hand_x, hand_y
  output logic [4*COORD_BITS-1:0] m_axis_tdata,
  // reachable, solved
  output logic [1:0]             m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LINK_BITS-1:0]   cfg_data_i
);

  logic                 en;
  logic [LINK_BITS-1:0] link_q;
  logic [LSQ_W-1:0]     l4sq_q;
  logic [LINK_BITS:0]   two_l;
  item_t                item;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;
  assign two_l         = {link_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LINK_RESET;
      l4sq_q <= L4SQ_RESET;
    end else begin
      if (cfg_valid_i) link_q <= cfg_data_i;
      l4sq_q <= LSQ_W'(two_l * two_l);
    end
  end

  assign item.target_x    = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
  assign item.target_y    = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
  assign item.base_x      = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
  assign item.base_y      = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
  assign item.shoulder_dx = s_axis_tdata[4*COORD_BITS +: COORD_BITS];
  assign item.shoulder_dy = s_axis_tdata[5*COORD_BITS +: COORD_BITS];
  assign item.elbow_side  = s_axis_tuser[0];
  assign item.arm_alive   = s_axis_tuser[1];

  logic            fr_valid;
  ctl_t            fr_ctl;
  logic [SQ_W-1:0] fr_sq1, fr_sq2;

  tlik_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (item),
    .two_l_i (two_l),
    .l4sq_i  (l4sq_q),
    .valid_o (fr_valid),
    .ctl_o   (fr_ctl),
    .sq1_o   (fr_sq1),
    .sq2_o   (fr_sq2)
  );

  logic            rt_valid;
  ctl_t            rt_ctl;
  logic [RT_W-1:0] rt1, rt2;

  tlik_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .ctl_i   (fr_ctl),
    .sq1_i   (fr_sq1),
    .sq2_i   (fr_sq2),
    .valid_o (rt_valid),
    .ctl_o   (rt_ctl),
    .rt1_o   (rt1),
    .rt2_o   (rt2)
  );

  // scale stages: products, rounding term, divisor, then rounded numerators
  logic             mv_q, av_q;
  ctl_t             mctl_q, actl_q;
  logic [PROD_W-1:0] px_q, py_q;
  logic [RT_W-1:0]  rnd_q;
  logic [DEN_W-1:0] mden_q, aden_q;
  logic [RM_W-1:0]  nx_q, ny_q;
  logic [RT_W-1:0]  mop;

  assign mop = rt_ctl.reach ? rt1 : RT_W'(link_q);

  logic            dv_valid;
  ctl_t            dv_ctl;
  logic [QW-1:0]   qx, qy;

  tlik_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (av_q),
    .ctl_i   (actl_q),
    .nx_i    (nx_q),
    .ny_i    (ny_q),
    .den_i   (aden_q),
    .valid_o (dv_valid),
    .ctl_o   (dv_ctl),
    .qx_o    (qx),
    .qy_o    (qy)
  );

  // elbow stage
  logic                    fv_q;
  ctl_t                    fctl_q;
  logic signed [EXT_W-1:0] ex_q, ey_q;
  logic signed [EXT_W-1:0] ex_d, ey_d, dxe, dye, qxe, qye, le, hfx, hfy, ta, tb;

  assign dxe = ext_d(dv_ctl.dx);
  assign dye = ext_d(dv_ctl.dy);
  assign qxe = $signed({{(EXT_W - QW){1'b0}}, qx});
  assign qye = $signed({{(EXT_W - QW){1'b0}}, qy});
  assign le  = $signed({{(EXT_W - LINK_BITS){1'b0}}, link_q});
  // halves truncate toward zero
  assign hfx = (dxe + $signed(EXT_W'(dv_ctl.dx[DIFF_W-1]))) >>> 1;
  assign hfy = (dye + $signed(EXT_W'(dv_ctl.dy[DIFF_W-1]))) >>> 1;
  assign ta  = dv_ctl.dy[DIFF_W-1] ? -qxe : qxe;
  assign tb  = dv_ctl.dx[DIFF_W-1] ? -qye : qye;

  always_comb begin
    priority if (!dv_ctl.reach && dv_ctl.zero) begin
      ex_d = le;
      ey_d = '0;
    end else if (!dv_ctl.reach) begin
      ex_d = dv_ctl.dx[DIFF_W-1] ? -qxe : qxe;
      ey_d = dv_ctl.dy[DIFF_W-1] ? -qye : qye;
    end else if (dv_ctl.zero) begin
      ex_d = '0;
      ey_d = dv_ctl.side ? le : -le;
    end else if (dv_ctl.side) begin
      ex_d = hfx - ta;
      ey_d = hfy + tb;
    end else begin
      ex_d = hfx + ta;
      ey_d = hfy - tb;
    end
  end

  // output register
  logic                    ov_q;
  logic [4*COORD_BITS-1:0] odata_q;
  logic [1:0]              ouser_q;
  logic signed [EXT_W-1:0] hx_d, hy_d;

  assign hx_d = fctl_q.reach ? ext_d(fctl_q.dx) - ex_q : ex_q;
  assign hy_d = fctl_q.reach ? ext_d(fctl_q.dy) - ey_q : ey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      av_q <= 1'b0;
      fv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      mv_q <= rt_valid;
      av_q <= mv_q;
      fv_q <= dv_valid;
      ov_q <= fv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mctl_q <= rt_ctl;
      px_q   <= PROD_W'(rt_ctl.mx * mop);
      py_q   <= PROD_W'(rt_ctl.my * mop);
      rnd_q  <= rt_ctl.reach ? rt2 : (rt1 >> 1);
      mden_q <= rt_ctl.reach ? {rt2, 1'b0} : {1'b0, rt1};

      actl_q <= mctl_q;
      nx_q   <= RM_W'(px_q) + RM_W'(rnd_q);
      ny_q   <= RM_W'(py_q) + RM_W'(rnd_q);
      aden_q <= mden_q;

      fctl_q <= dv_ctl;
      ex_q   <= ex_d;
      ey_q   <= ey_d;

      if (fctl_q.alive) begin
        odata_q <= {sat_coord(hy_d), sat_coord(hx_d), sat_coord(ey_q), sat_coord(ex_q)};
        ouser_q <= {1'b1, fctl_q.reach};
      end else begin
        odata_q <= '0;
        ouser_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // an unsolved beat carries nothing
  a_dead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
    else $error("unsolved beat with nonzero payload");

  // stretched links point the same way
  a_straight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0]) |->
      (m_axis_tdata[2*COORD_BITS-1:0] == m_axis_tdata[4*COORD_BITS-1:2*COORD_BITS]))
    else $error("stretched beat with elbow and hand differing");

  // a stalled output freezes the input side too
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> (!s_axis_tready ##1 $stable(fv_q)))
    else $error("pipe moved during output stall");

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for two_link_planar_ik, directed then random beats, each
// checked with a table row or a built-in arm solver. Depends on tlik_pkg and the rtl.
`timescale 1ns / 1ps

module tb_top;
  import tlik_pkg::*;

  localparam int LATENCY = 64;

  typedef struct packed {
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COORD_BITS-1:0] hx;
    logic [COORD_BITS-1:0] hy;
    logic                  reach;
    logic                  solved;
  } arm_res_t;

  typedef struct {
    item_t    it;
    logic     known;
    arm_res_t res;
  } row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic [6*COORD_BITS-1:0] s_axis_tdata = '0;
  logic [1:0]              s_axis_tuser = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [4*COORD_BITS-1:0] m_axis_tdata;
  logic [1:0]              m_axis_tuser;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [LINK_BITS-1:0]    cfg_data_i = '0;

  logic [LINK_BITS-1:0] link_len;
  arm_res_t             pose_q[$];
  int                   n_err = 0;
  bit                   feed_done = 0;

  two_link_planar_ik u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned div_round(longint unsigned n, longint unsigned d);
    return (n + d / 2) / d;
  endfunction

  function automatic longint signed signed_as(longint unsigned m, longint signed s);
    return (s < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(longint signed v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic arm_res_t solve_arm(item_t it, logic [LINK_BITS-1:0] len);
    arm_res_t r;
    longint signed dx, dy, ex, ey, hx, hy;
    longint unsigned ax, ay, ll, two_l, s, q, hq, a, top, amag;
    bit reach;
    r = '0;
    if (!it.arm_alive) return r;
    ll = len;
    two_l = 2 * ll;
    reach = 0;
    dx = longint'(it.target_x) - longint'(it.base_x) - longint'(it.shoulder_dx);
    dy = longint'(it.target_y) - longint'(it.base_y) - longint'(it.shoulder_dy);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax < two_l && ay < two_l) begin
      s = ax * ax + ay * ay;
      reach = s < two_l * two_l;
      if (reach) begin
        if (s == 0) begin
          ex = 0;
          ey = it.elbow_side ? longint'(ll) : -longint'(ll);
        end else begin
          q = two_l * two_l - s;
          hq = root_floor(q << 16);
          a = root_floor(s << 16);
          // perpendicular offset of the elbow from the midpoint of d
          if (it.elbow_side) begin
            ex = dx / 2 - signed_as(div_round(ay * hq, 2 * a), dy);
            ey = dy / 2 + signed_as(div_round(ax * hq, 2 * a), dx);
          end else begin
            ex = dx / 2 + signed_as(div_round(ay * hq, 2 * a), dy);
            ey = dy / 2 - signed_as(div_round(ax * hq, 2 * a), dx);
          end
        end
        hx = dx - ex;
        hy = dy - ey;
      end
    end
    if (!reach) begin
      if (ax == 0 && ay == 0) begin
        ex = ll;
        ey = 0;
      end else begin
        top = 64'd1 << 30;
        while (ax >= top || ay >= top) begin
          ax >>= 1;
          ay >>= 1;
        end
        while (ax < top / 2 && ay < top / 2) begin
          ax <<= 1;
          ay <<= 1;
        end
        amag = root_floor(ax * ax + ay * ay);
        ex = signed_as(div_round(ax * ll, amag), dx);
        ey = signed_as(div_round(ay * ll, amag), dy);
      end
      hx = ex;
      hy = ey;
    end
    r.ex = clamp(ex);
    r.ey = clamp(ey);
    r.hx = clamp(hx);
    r.hy = clamp(hy);
    r.reach = reach;
    r.solved = 1'b1;
    return r;
  endfunction

  function automatic logic [COORD_BITS-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      1, 2: return COORD_BITS'($signed($urandom_range(0, 40000)) - 20000);
      3: return COORD_BITS'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic item_t rnd_item();
    item_t it;
    it.target_x = rnd_coord();
    it.target_y = rnd_coord();
    it.base_x = rnd_coord();
    it.base_y = rnd_coord();
    it.shoulder_dx = $urandom_range(0, 3) == 0 ? rnd_coord() : '0;
    it.shoulder_dy = $urandom_range(0, 3) == 0 ? rnd_coord() : '0;
    it.elbow_side = $urandom_range(0, 1);
    it.arm_alive = $urandom_range(0, 7) != 0;
    return it;
  endfunction

  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_link(logic [LINK_BITS-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    link_len = v;
  endtask

  // tvalid stays high after a beat unless an idle gap follows
  task automatic send_arm(item_t it, logic known, arm_res_t want);
    int n_idle;
    n_idle = $urandom_range(0, 4);
    if (n_idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n_idle) @(posedge clk_i);
    end
    s_axis_tdata <= {it.shoulder_dy, it.shoulder_dx, it.base_y, it.base_x,
                     it.target_y, it.target_x};
    s_axis_tuser <= {it.arm_alive, it.elbow_side};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pose_q.push_back(known ? want : solve_arm(it, link_len));
  endtask

  function automatic item_t mk(int tx, int ty, int bx, int by, bit side, bit alive);
    item_t it;
    it = '0;
    it.target_x = COORD_BITS'(tx);
    it.target_y = COORD_BITS'(ty);
    it.base_x = COORD_BITS'(bx);
    it.base_y = COORD_BITS'(by);
    it.elbow_side = side;
    it.arm_alive = alive;
    return it;
  endfunction

  function automatic arm_res_t mr(int ex, int ey, int hx, int hy, bit reach);
    return '{COORD_BITS'(ex), COORD_BITS'(ey), COORD_BITS'(hx), COORD_BITS'(hy), reach, 1'b1};
  endfunction

  initial begin
    row_t rows[$];
    item_t it;
    rows.push_back('{mk(0, 0, 0, 0, 1, 1), 1, mr(0, 25600, 0, -25600, 1)});
    rows.push_back('{mk(0, 0, 0, 0, 0, 1), 1, mr(0, -25600, 0, 25600, 1)});
    rows.push_back('{mk(1234, 77, 0, 0, 1, 0), 1, '0});
    rows.push_back('{mk(51200, 0, 0, 0, 1, 1), 1, mr(25600, 0, 25600, 0, 0)});
    rows.push_back('{mk(0, -51200, 0, 0, 0, 1), 1, mr(0, -25600, 0, -25600, 0)});
    rows.push_back('{mk(8388607, 8388607, -8388608, -8388608, 1, 1), 0, '0});
    rows.push_back('{mk(-8388608, -8388608, 8388607, 8388607, 0, 1), 0, '0});
    rows.push_back('{mk(8388607, -8388608, 0, 0, 1, 1), 0, '0});
    rows.push_back('{mk(30000, 20000, 100, -100, 1, 1), 0, '0});
    rows.push_back('{mk(30000, 20000, 100, -100, 0, 1), 0, '0});
    rows.push_back('{mk(-1, 1, 0, 0, 0, 1), 0, '0});
    rows.push_back('{mk(51199, 0, 0, 0, 1, 1), 0, '0});
    rows.push_back('{mk(-36000, 36000, 0, 0, 1, 1), 0, '0});
    it = mk(100, 200, 0, 0, 1, 1);
    it.shoulder_dx = 24'h7fffff;
    it.shoulder_dy = 24'h800000;
    rows.push_back('{it, 0, '0});

    link_len = 25600;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_arm(rows[i].it, rows[i].known, rows[i].res);
    drain_pipe();
    // zero link: every target unreachable, zero vector points along +x
    write_link('0);
    send_arm(mk(0, 0, 0, 0, 1, 1), 1, mr(0, 0, 0, 0, 0));
    send_arm(mk(5, -3, 0, 0, 1, 1), 0, '0);
    drain_pipe();
    write_link('1);
    send_arm(mk(8388607, 8388607, -8388608, -8388608, 0, 1), 0, '0);
    send_arm(mk(1000, -1000, 0, 0, 1, 1), 0, '0);
    for (int ph = 0; ph < 5; ph++) begin
      drain_pipe();
      case (ph)
        0: write_link(1);
        1: write_link(25600);
        2: write_link($urandom_range(1, 4194303));
        3: write_link($urandom_range(1, 2000000));
        default: write_link($urandom_range(1000, 40000));
      endcase
      for (int k = 0; k < 400; k++) send_arm(rnd_item(), 0, '0);
    end
    drain_pipe();
    feed_done = 1;
  end

  // output side: random backpressure, compare each beat with the oldest prediction
  initial begin
    arm_res_t want, got;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48],
               m_axis_tdata[95:72], m_axis_tuser[0], m_axis_tuser[1]};
        if (pose_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected beat %h", got);
        end else begin
          want = pose_q.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("mismatch exp ex %h ey %h hx %h hy %h r %b s %b / got %h %h %h %h %b %b",
                       want.ex, want.ey, want.hx, want.hy, want.reach, want.solved,
                       got.ex, got.ey, got.hx, got.hy, got.reach, got.solved);
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
    end
  end

  initial begin
    wait (feed_done);
    if (n_err == 0 && pose_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
